// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of the decoder.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define U8DEC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define U8DEC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/u8dec_pkg.sv =====
// Types, constants and lead-byte helpers of the lenient UTF-8 decoder.
// No dependencies; imported by the decode logic, result queue, top level and testbenches.
package u8dec_pkg;

	localparam int CP_WIDTH  = 21;
	localparam int LEN_WIDTH = 3;
	localparam int MAX_RES   = 3;

	// Lead-byte classification masks and patterns.
	localparam logic [7:0] ASCII_MASK = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_PAT  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_PAT  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_PAT  = 8'hF0;

	// Payload bits kept from lead and continuation bytes.
	localparam logic [7:0] LEAD2_BITS = 8'h1F;
	localparam logic [7:0] LEAD3_BITS = 8'h0F;
	localparam logic [7:0] LEAD4_BITS = 8'h07;
	localparam logic [7:0] CONT_BITS  = 8'h3F;

	// Sequence lengths; LEN_NONE marks a byte that cannot start a sequence.
	localparam logic [LEN_WIDTH-1:0] LEN_NONE = 3'd0;
	localparam logic [LEN_WIDTH-1:0] LEN_ONE  = 3'd1;
	localparam logic [LEN_WIDTH-1:0] LEN_TWO  = 3'd2;
	localparam logic [LEN_WIDTH-1:0] LEN_THR  = 3'd3;
	localparam logic [LEN_WIDTH-1:0] LEN_FOUR = 3'd4;

	typedef struct packed {
		logic [CP_WIDTH-1:0]  cp;
		logic [LEN_WIDTH-1:0] len;
	} res_t;

	// Control from the decode logic to the top level and result queue.
	typedef struct packed {
		logic [1:0] res_cnt;   // results produced by this beat, 0 to 3
		logic       hold;      // the input byte joins the held sequence
		logic       text_end;  // beat closes the text
		logic [1:0] held_nxt;  // held byte count after this beat
	} dec_ctrl_t;

	function automatic logic [LEN_WIDTH-1:0] lead_length(input logic [7:0] b);
		logic [LEN_WIDTH-1:0] len;
		if ((b & ASCII_MASK) == 8'h00)
			len = LEN_ONE;
		else if ((b & LEAD2_MASK) == LEAD2_PAT)
			len = LEN_TWO;
		else if ((b & LEAD3_MASK) == LEAD3_PAT)
			len = LEN_THR;
		else if ((b & LEAD4_MASK) == LEAD4_PAT)
			len = LEN_FOUR;
		else
			len = LEN_NONE;
		return len;
	endfunction

endpackage

// ===== hw/rtl/u8dec_byte_if.sv =====
// Valid/ready channel that carries one text byte per beat into the decoder.
// Standalone; no package dependencies.
interface u8dec_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== hw/rtl/u8dec_cp_if.sv =====
// Valid/ready channel that carries one decoded code point per beat.
// Standalone; the offset width is set by the OFFSET_WIDTH parameter.
interface u8dec_cp_if #(
	parameter int OFFSET_WIDTH = 16
);
	logic                    valid;
	logic                    ready;
	logic [20:0]             code_point;
	logic [OFFSET_WIDTH-1:0] byte_offset;
	logic [2:0]              byte_length;
	logic                    run_last;
	logic                    text_last;

	modport source (output valid, output code_point, output byte_offset,
		output byte_length, output run_last, output text_last, input ready);
	modport sink (input valid, input code_point, input byte_offset,
		input byte_length, input run_last, input text_last, output ready);
endinterface

// ===== hw/rtl/u8dec_decode.sv =====
// Combinational decode of one byte against the held partial sequence.
// Depends on u8dec_pkg for result types and lead-byte helpers.
module u8dec_decode #(
	parameter int OFFSET_WIDTH = 16
) (
	input  logic [7:0]                          text_byte,
	input  logic                                end_of_text,
	input  logic [2:0][7:0]                     held_bytes,
	input  logic [1:0]                          held_count,
	input  logic [OFFSET_WIDTH-1:0]             next_offset,
	output u8dec_pkg::res_t [2:0]               res,
	output logic [2:0][OFFSET_WIDTH-1:0]        res_offset,
	output u8dec_pkg::dec_ctrl_t                ctrl,
	output logic [OFFSET_WIDTH-1:0]             next_offset_nxt
);
	import u8dec_pkg::*;

	// Saturating add of a small byte count to an offset.
	function automatic logic [OFFSET_WIDTH-1:0] sat_add(
		input logic [OFFSET_WIDTH-1:0] base,
		input logic [2:0]              inc
	);
		logic [OFFSET_WIDTH:0] sum;
		sum = {1'b0, base} + (OFFSET_WIDTH+1)'(inc);
		return sum[OFFSET_WIDTH] ? {OFFSET_WIDTH{1'b1}} : sum[OFFSET_WIDTH-1:0];
	endfunction

	logic [7:0]           buf0, buf1, buf2, buf3;
	logic [LEN_WIDTH-1:0] len_in, len_lead, len_rem, seq_n;
	logic [CP_WIDTH-1:0]  full_cp, rem2_cp;
	logic [2:0][1:0]      pos;
	logic [2:0]           consumed;

	// Sequence bytes in order: held bytes first, then the new byte.
	assign buf0 = (held_count == 2'd0) ? text_byte : held_bytes[0];
	assign buf1 = (held_count == 2'd1) ? text_byte : held_bytes[1];
	assign buf2 = (held_count == 2'd2) ? text_byte : held_bytes[2];
	assign buf3 = text_byte;

	assign len_in   = lead_length(text_byte);
	assign len_lead = lead_length(held_bytes[0]);
	assign len_rem  = lead_length(buf1);
	assign seq_n    = LEN_WIDTH'(held_count) + LEN_WIDTH'(1);

	always_comb begin
		case (len_lead)
			LEN_TWO:  full_cp = CP_WIDTH'({buf0 & LEAD2_BITS, buf1[5:0]});
			LEN_THR:  full_cp = CP_WIDTH'({buf0 & LEAD3_BITS, buf1[5:0], buf2[5:0]});
			LEN_FOUR: full_cp = CP_WIDTH'({buf0[2:0] & LEAD4_BITS[2:0], buf1[5:0],
				buf2[5:0], buf3[5:0]});
			default:  full_cp = CP_WIDTH'(buf0);
		endcase
	end

	assign rem2_cp = CP_WIDTH'({buf1[4:0] & LEAD2_BITS[4:0], buf2[5:0] & CONT_BITS[5:0]});

	always_comb begin
		res           = '0;
		pos           = '0;
		consumed      = 3'd0;
		ctrl.res_cnt  = 2'd0;
		ctrl.hold     = 1'b0;
		ctrl.text_end = end_of_text;
		if (held_count == 2'd0) begin
			// Fresh byte: single-byte code point, a truncated lead at the end, or held.
			if (len_in == LEN_NONE || len_in == LEN_ONE || end_of_text) begin
				res[0]       = '{cp: CP_WIDTH'(text_byte), len: LEN_ONE};
				ctrl.res_cnt = 2'd1;
				consumed     = 3'd1;
			end else begin
				ctrl.hold = 1'b1;
			end
		end else if (seq_n == len_lead) begin
			res[0]       = '{cp: full_cp, len: len_lead};
			ctrl.res_cnt = 2'd1;
			consumed     = seq_n;
		end else if (end_of_text) begin
			// Truncated sequence: the lead goes out alone and the rest is decoded again.
			res[0] = '{cp: CP_WIDTH'(buf0), len: LEN_ONE};
			pos[1] = 2'd1;
			if (held_count == 2'd1) begin
				res[1]       = '{cp: CP_WIDTH'(buf1), len: LEN_ONE};
				ctrl.res_cnt = 2'd2;
			end else if (len_rem == LEN_TWO) begin
				res[1]       = '{cp: rem2_cp, len: LEN_TWO};
				ctrl.res_cnt = 2'd2;
			end else begin
				res[1]       = '{cp: CP_WIDTH'(buf1), len: LEN_ONE};
				res[2]       = '{cp: CP_WIDTH'(buf2), len: LEN_ONE};
				pos[2]       = 2'd2;
				ctrl.res_cnt = 2'd3;
			end
			consumed = seq_n;
		end else begin
			ctrl.hold = 1'b1;
		end
		// A byte is only held when the text goes on, so the count grows by one.
		ctrl.held_nxt = ctrl.hold ? held_count + 2'd1 : 2'd0;
	end

	// Saturation is monotone, so each offset is one clamped add from the base.
	always_comb begin
		for (int k = 0; k < MAX_RES; k++)
			res_offset[k] = sat_add(next_offset, {1'b0, pos[k]});
	end

	assign next_offset_nxt = end_of_text ? '0 : sat_add(next_offset, consumed);

endmodule

// ===== hw/rtl/u8dec_res_queue.sv =====
// Result register for up to three code points of one input beat, drained in order.
// Depends on u8dec_pkg and drives the u8dec_cp_if output channel.
module u8dec_res_queue #(
	parameter int OFFSET_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  u8dec_pkg::res_t [2:0]        res,
	input  logic [2:0][OFFSET_WIDTH-1:0] res_offset,
	input  u8dec_pkg::dec_ctrl_t         ctrl,
	output logic                         can_load,
	u8dec_cp_if.source                   cps
);
	import u8dec_pkg::*;

	logic [1:0]                   rem_q;
	logic                         text_end_q;
	res_t [2:0]                   ent_q;
	logic [2:0][OFFSET_WIDTH-1:0] off_q;
	logic                         fire;

	assign fire     = cps.valid && cps.ready;
	assign can_load = (rem_q == 2'd0) || (rem_q == 2'd1 && cps.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 2'd0;
		end else if (load) begin
			rem_q <= ctrl.res_cnt;
		end else if (fire) begin
			rem_q <= rem_q - 2'd1;
		end
	end

	// Entries shift toward slot 0 so the head is always a plain register.
	always_ff @(posedge clk) begin
		if (load) begin
			ent_q      <= res;
			off_q      <= res_offset;
			text_end_q <= ctrl.text_end;
		end else if (fire) begin
			ent_q[0] <= ent_q[1];
			ent_q[1] <= ent_q[2];
			off_q[0] <= off_q[1];
			off_q[1] <= off_q[2];
		end
	end

	assign cps.valid       = (rem_q != 2'd0);
	assign cps.code_point  = ent_q[0].cp;
	assign cps.byte_offset = off_q[0];
	assign cps.byte_length = ent_q[0].len;
	assign cps.run_last    = (rem_q == 2'd1);
	assign cps.text_last   = text_end_q && (rem_q == 2'd1);

endmodule

// ===== hw/rtl/utf8_lenient_decoder.sv =====
// Top level of the lenient streaming UTF-8 decoder: input register, held state.
// Depends on u8dec_pkg, u8dec_byte_if, u8dec_cp_if, u8dec_decode, u8dec_res_queue.
//
//   Channel  | Role | Beat payload
//   ---------+------+-------------------------------------------------------------
//   byte_ch  | in   | text_byte, end_of_text
//   cp_ch    | out  | code_point, byte_offset, byte_length, run_last, text_last
//
// A byte beat is registered and decoded in the following cycle; its results are
// loaded into the result queue once it has room and are offered from the queue
// register. The decoder takes one byte per cycle as long as each byte yields at
// most one code point and the sink keeps up; the queue drains one code point per
// cycle while the sink is ready, so a truncated end of text holds the input until
// its code points drain. arst_n clears all control state; held bytes do not need
// it. A stall on cp_ch backs up into the input register and then byte_ch.
module utf8_lenient_decoder #(
	parameter int OFFSET_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	u8dec_byte_if.sink  byte_ch,
	u8dec_cp_if.source  cp_ch
);
	import u8dec_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// Partial sequence carried between bytes. Only entries below the count are read.
	logic [2:0][7:0]         held_bytes_q;
	logic [1:0]              held_count_q;
	logic [OFFSET_WIDTH-1:0] next_offset_q;

	res_t [2:0]                   res;
	logic [2:0][OFFSET_WIDTH-1:0] res_offset;
	dec_ctrl_t                    ctrl;
	logic [OFFSET_WIDTH-1:0]      next_offset_nxt;
	logic                         can_load;
	logic                         advance;
	logic                         in_fire;

	// The registered byte moves on once the queue has room for its results.
	assign advance       = valid_s1 && can_load;
	assign byte_ch.ready = !valid_s1 || advance;
	assign in_fire       = byte_ch.valid && byte_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= byte_ch.text_byte;
			last_s1 <= byte_ch.end_of_text;
		end
	end

	// Held state advances together with the byte that was decoded against it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count_q  <= 2'd0;
			next_offset_q <= '0;
		end else if (advance) begin
			held_count_q  <= ctrl.held_nxt;
			next_offset_q <= next_offset_nxt;
		end
	end

	// A held byte is always appended at the current count, which is below three.
	always_ff @(posedge clk) begin
		if (advance && ctrl.hold) begin
			held_bytes_q[held_count_q] <= byte_s1;
		end
	end

	u8dec_decode #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_decode (
		.text_byte      (byte_s1),
		.end_of_text    (last_s1),
		.held_bytes     (held_bytes_q),
		.held_count     (held_count_q),
		.next_offset    (next_offset_q),
		.res            (res),
		.res_offset     (res_offset),
		.ctrl           (ctrl),
		.next_offset_nxt(next_offset_nxt)
	);

	u8dec_res_queue #(
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_res_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.res       (res),
		.res_offset(res_offset),
		.ctrl      (ctrl),
		.can_load  (can_load),
		.cps       (cp_ch)
	);

endmodule

// ===== hw/rtl/u8dec_checker.sv =====
// Port-level checks on the decoder's output channel, bound to the top level.
// Depends on assert_macros.svh and on utf8_lenient_decoder for the bind.
`include "assert_macros.svh"

module u8dec_checker #(
	parameter int OFFSET_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [20:0]             code_point,
	input logic [OFFSET_WIDTH-1:0] byte_offset,
	input logic [2:0]              byte_length,
	input logic                    run_last,
	input logic                    text_last
);
	logic out_fire;

	assign out_fire = out_valid && out_ready;

	`U8DEC_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(code_point) && $stable(byte_offset) && $stable(byte_length), "output beat changed while stalled")

	`U8DEC_ASSERT_NOW(a_text_last_run, out_valid && text_last, run_last, "text end without end of run")

	`U8DEC_ASSERT_NXT(a_run_continues, out_fire && !run_last, out_valid, "results of one byte not back to back")

	`U8DEC_ASSERT_NXT(a_offset_step, out_fire && !run_last, byte_offset == $past(byte_offset) + OFFSET_WIDTH'($past(byte_length)) || (&byte_offset), "offset does not follow previous code point")

endmodule

bind utf8_lenient_decoder u8dec_checker #(
	.OFFSET_WIDTH(OFFSET_WIDTH)
) u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (cp_ch.valid),
	.out_ready  (cp_ch.ready),
	.code_point (cp_ch.code_point),
	.byte_offset(cp_ch.byte_offset),
	.byte_length(cp_ch.byte_length),
	.run_last   (cp_ch.run_last),
	.text_last  (cp_ch.text_last)
);

// ===== tb/utf8_lenient_decoder_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the lenient UTF-8 decoder. It follows the byte and code point beats,
// predicts the code points of every byte and checks them in order.
// Depends on u8dec_pkg, u8dec_byte_if and u8dec_cp_if.
module utf8_lenient_decoder_checker #(
	parameter int OFFSET_WIDTH = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	u8dec_byte_if byte_ch,
	u8dec_cp_if   cp_ch,
	output int    fail_count,
	output int    pending
);
	import u8dec_pkg::*;

	localparam logic [OFFSET_WIDTH-1:0] OFFSET_TOP = '1;
	localparam int REPORT_CAP = 40;

	typedef struct packed {
		logic [CP_WIDTH-1:0]     cp;
		logic [OFFSET_WIDTH-1:0] offset;
		logic [LEN_WIDTH-1:0]    len;
		logic                    run_last;
		logic                    text_last;
	} cp_beat_t;

	cp_beat_t                cp_expect_q[$];
	logic [7:0]              held_seq [3];
	int                      held_n = 0;
	logic [OFFSET_WIDTH-1:0] cursor = '0;
	int                      errs = 0;
	int                      queued = 0;

	assign fail_count = errs;
	assign pending    = queued;

	function automatic logic [LEN_WIDTH-1:0] seq_len_of(input logic [7:0] b);
		casez (b)
			8'b0???????: return LEN_ONE;
			8'b110?????: return LEN_TWO;
			8'b1110????: return LEN_THR;
			8'b11110???: return LEN_FOUR;
			default:     return LEN_NONE;
		endcase
	endfunction

	// Queues one code point at the current offset, then moves the offset on,
	// holding it at its top value once it would wrap.
	function automatic void queue_cp(input logic [CP_WIDTH-1:0] cp,
			input logic [LEN_WIDTH-1:0] len);
		cp_beat_t              beat;
		logic [OFFSET_WIDTH:0] sum;
		beat.cp        = cp;
		beat.offset    = cursor;
		beat.len       = len;
		beat.run_last  = 1'b0;
		beat.text_last = 1'b0;
		cp_expect_q = {cp_expect_q, beat};
		sum = cursor + len;
		cursor = sum[OFFSET_WIDTH] ? OFFSET_TOP : sum[OFFSET_WIDTH-1:0];
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eot);
		logic [7:0]           seq [4];
		logic [LEN_WIDTH-1:0] len;
		logic [CP_WIDTH-1:0]  value;
		cp_beat_t             tail;
		int                   n;
		int                   pos;
		int                   made;
		bit                   stop;
		for (int i = 0; i < held_n; i++)
			seq[i] = held_seq[i];
		seq[held_n] = b;
		n = held_n + 1;
		pos = 0;
		made = 0;
		stop = 1'b0;
		while (pos < n && !stop) begin
			len = seq_len_of(seq[pos]);
			if (len == LEN_NONE || len == LEN_ONE) begin
				queue_cp(CP_WIDTH'(seq[pos]), LEN_ONE);
				pos++;
				made++;
			end else if (pos + int'(len) <= n) begin
				case (len)
					LEN_TWO: value = CP_WIDTH'(seq[pos] & LEAD2_BITS);
					LEN_THR: value = CP_WIDTH'(seq[pos] & LEAD3_BITS);
					default: value = CP_WIDTH'(seq[pos] & LEAD4_BITS);
				endcase
				for (int j = 1; j < int'(len); j++)
					value = (value << 6) | CP_WIDTH'(seq[pos + j] & CONT_BITS);
				queue_cp(value, len);
				pos += int'(len);
				made++;
			end else if (eot) begin
				// A lead cut off by the end of the text goes out alone; what
				// followed it is decoded again on the next pass of the loop.
				queue_cp(CP_WIDTH'(seq[pos]), LEN_ONE);
				pos++;
				made++;
			end else begin
				stop = 1'b1;
			end
		end
		held_n = 0;
		while (pos < n && held_n < 3) begin
			held_seq[held_n] = seq[pos];
			held_n++;
			pos++;
		end
		if (made > 0) begin
			tail = cp_expect_q.pop_back();
			tail.run_last = 1'b1;
			tail.text_last = eot;
			cp_expect_q = {cp_expect_q, tail};
		end
		if (eot) begin
			held_n = 0;
			cursor = '0;
		end
	endfunction

	function automatic void flag(input string what, input longint unsigned want,
			input longint unsigned got);
		if (errs < REPORT_CAP)
			$error("%s mismatch: expected 'h%0h, actual 'h%0h", what, want, got);
		errs++;
	endfunction

	always @(posedge clk) begin : watch
		cp_beat_t want;
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				decode_byte(byte_ch.text_byte, byte_ch.end_of_text);
			if (cp_ch.valid && cp_ch.ready) begin
				if (cp_expect_q.size() == 0) begin
					if (errs < REPORT_CAP)
						$error("code point beat 'h%0h with no code point expected",
							cp_ch.code_point);
					errs++;
				end else begin
					want = cp_expect_q.pop_front();
					if (cp_ch.code_point !== want.cp)
						flag("code_point", want.cp, cp_ch.code_point);
					if (cp_ch.byte_offset !== want.offset)
						flag("byte_offset", want.offset, cp_ch.byte_offset);
					if (cp_ch.byte_length !== want.len)
						flag("byte_length", want.len, cp_ch.byte_length);
					if (cp_ch.run_last !== want.run_last)
						flag("run_last", want.run_last, cp_ch.run_last);
					if (cp_ch.text_last !== want.text_last)
						flag("text_last", want.text_last, cp_ch.text_last);
				end
			end
			queued = cp_expect_q.size();
		end
	end

endmodule

// ===== tb/utf8_lenient_decoder_tb.sv =====
`timescale 1ns / 100ps
// Testbench top of the lenient UTF-8 decoder: clock, reset, byte stimulus, sink stalls.
// Depends on u8dec_pkg, both channel interfaces, the decoder and its checker.
module utf8_lenient_decoder_tb;
	import u8dec_pkg::*;

	localparam int OFFSET_WIDTH    = 16;
	localparam int RANDOM_BYTES    = 160;
	localparam int SQUEEZE_CYCLES  = 200;
	localparam int DRAIN_CYCLES    = 10;
	localparam int CYCLE_LIMIT     = 500000;

	// Directed beats, end_of_text in bit 8 and the byte below it. They run through
	// the ASCII extremes, a complete sequence of each multibyte length, a second
	// four byte one with the largest value a four byte lead can carry, stray
	// continuations, bytes that are no lead at all, a four byte sequence cut off
	// by the end of the text so that each held byte comes out alone, a one byte
	// text and a lone lead that makes up a text of its own.
	localparam logic [8:0] DIRECTED_BEATS [24] = '{
		9'h000, 9'h07F,
		9'h0C2, 9'h0A9,
		9'h0E2, 9'h082, 9'h0AC,
		9'h0F0, 9'h09F, 9'h098, 9'h080,
		9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
		9'h080, 9'h0BF, 9'h0F8, 9'h0FF,
		9'h0F0, 9'h09F, 9'h198,
		9'h141,
		9'h1C3
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	int         fail_count;
	int         pending;
	// Sender and receiver start random idle gaps only while this is set.
	bit         idle_en = 1'b1;
	// Asks the receiver for one long hold-off.
	bit         squeeze_req = 1'b0;
	logic [7:0] text_q[$];

	u8dec_byte_if byte_ch ();
	u8dec_cp_if #(.OFFSET_WIDTH(OFFSET_WIDTH)) cp_ch ();

	utf8_lenient_decoder #(.OFFSET_WIDTH(OFFSET_WIDTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.cp_ch   (cp_ch)
	);

	utf8_lenient_decoder_checker #(.OFFSET_WIDTH(OFFSET_WIDTH)) checker_inst (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.cp_ch      (cp_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	// Idle length in cycles: usually none or a few, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	// A lead byte for a sequence of the given length, with random payload bits.
	function automatic logic [7:0] lead_byte(input logic [LEN_WIDTH-1:0] len);
		logic [7:0] r;
		r = 8'($urandom);
		case (len)
			LEN_ONE: return {1'b0, r[6:0]};
			LEN_TWO: return {3'b110, r[4:0]};
			LEN_THR: return {4'b1110, r[3:0]};
			default: return {5'b11110, r[2:0]};
		endcase
	endfunction

	// Appends a lead for a sequence of len bytes and keep - 1 continuations after
	// it. With keep below len the sequence is left unfinished, and whatever comes
	// next is swallowed as its continuation or it is cut off by the end of text.
	function automatic void add_seq(input logic [LEN_WIDTH-1:0] len, input int keep);
		logic [7:0] r;
		text_q = {text_q, lead_byte(len)};
		for (int i = 1; i < keep; i++) begin
			r = 8'($urandom);
			text_q = {text_q, {2'b10, r[5:0]}};
		end
	endfunction

	// One random text: mostly well-formed sequences, with raw noise bytes and
	// sequences broken off early mixed in.
	function automatic void fill_text();
		int                   units;
		int                   kind;
		logic [LEN_WIDTH-1:0] len;
		text_q.delete();
		units = $urandom_range(1, 10);
		for (int u = 0; u < units; u++) begin
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				len = LEN_WIDTH'($urandom_range(1, 4));
				add_seq(len, int'(len));
			end else if (kind < 85) begin
				text_q = {text_q, 8'($urandom)};
			end else begin
				len = LEN_WIDTH'($urandom_range(2, 4));
				add_seq(len, $urandom_range(1, int'(len) - 1));
			end
		end
	endfunction

	// Offers one byte beat and returns at the edge where it is taken. An idle gap,
	// if any, comes first with valid low. When the next beat follows at once,
	// valid simply stays high.
	task automatic push_byte(input logic [7:0] b, input logic eot);
		int n;
		n = idle_en ? gap_len() : 0;
		if (n > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.text_byte <= b;
		byte_ch.end_of_text <= eot;
		do
			@(posedge clk);
		while (!(byte_ch.valid && byte_ch.ready));
	endtask

	// Sends the bytes of text_q with end_of_text on the last one.
	task automatic send_text();
		foreach (text_q[i])
			push_byte(text_q[i], i == text_q.size() - 1);
	endtask

	// Receiver: between stalls ready is high. While idling is on it starts a stall
	// now and then. It also performs the one long hold-off, counted here, during
	// which the sender keeps offering bytes until the decoder backs up.
	initial begin : sink_side
		int stall_left;
		bit squeeze_done;
		stall_left = 0;
		squeeze_done = 1'b0;
		cp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (stall_left == 0) begin
				if (squeeze_req && !squeeze_done) begin
					stall_left = SQUEEZE_CYCLES;
					squeeze_done = 1'b1;
				end else if (idle_en && $urandom_range(0, 3) == 0) begin
					stall_left = gap_len();
				end
			end
			if (stall_left > 0) begin
				cp_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				cp_ch.ready <= 1'b1;
			end
		end
	end

	// The worst run, with every beat behind the longest gaps and the long hold-off,
	// stays well below this limit.
	initial begin : watchdog
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		int sent;
		byte_ch.valid = 1'b0;
		byte_ch.text_byte = '0;
		byte_ch.end_of_text = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_BEATS[i])
			push_byte(DIRECTED_BEATS[i][7:0], DIRECTED_BEATS[i][8]);

		// One text with no idling on either side: a complete sequence of each
		// multibyte length, then a four byte lead cut off by the end of the text.
		idle_en = 1'b0;
		text_q.delete();
		add_seq(LEN_TWO, 2);
		add_seq(LEN_THR, 3);
		add_seq(LEN_FOUR, 4);
		add_seq(LEN_FOUR, 2);
		send_text();

		// Random texts. Idling is off for about one text in five, and the long
		// hold-off on the receiver falls at the start of this part.
		squeeze_req = 1'b1;
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			idle_en = ($urandom_range(0, 4) != 0);
			fill_text();
			sent += text_q.size();
			send_text();
		end
		byte_ch.valid <= 1'b0;
		idle_en = 1'b1;

		// Let the checker count the code points of the last byte first. Then let every
		// expected code point arrive and wait out the drain time so that a stray extra
		// beat would still show up in the checker.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/u8dec_pkg.sv
hw/rtl/u8dec_byte_if.sv
hw/rtl/u8dec_cp_if.sv
hw/rtl/u8dec_decode.sv
hw/rtl/u8dec_res_queue.sv
hw/rtl/utf8_lenient_decoder.sv
hw/rtl/u8dec_checker.sv
tb/utf8_lenient_decoder_checker.sv
tb/utf8_lenient_decoder_tb.sv
